[src/ssc_pkg.sv]
package ssc_pkg;

  // Coordinate and intermediate widths fixed by the segment format.
  localparam int COORD_W    = 20;
  localparam int ROOT_XBITS = 11;
  localparam int ROOT_W     = 32;
  localparam int NUM_W      = 35;
  localparam int DISC_W     = 44;
  localparam int RAD_W      = 64;
  localparam int DX_W       = COORD_W + 1;
  localparam int QX_W       = COORD_W + 2;

  // Job kinds decided by the front end.
  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_LINQ = 2'd1;
  localparam logic [1:0] KIND_QUAD = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One classified segment, ready for the solver.
  typedef struct packed {
    coord_t                  x0;
    logic signed [DX_W-1:0]  dx1;
    logic signed [QX_W-1:0]  qx;
    logic signed [DX_W-1:0]  dx2;
    logic [1:0]              kind;
    logic                    rise1;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] den;
    logic signed [NUM_W-1:0] e;
    logic [RAD_W-1:0]        rad;
  } seg_job_t;

  typedef struct packed {
    logic     valid;
    seg_job_t job;
  } job_req_t;

endpackage

[src/ssc_if.sv]
// Segment request channel.
interface ssc_in_if import ssc_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t ctrl_x;
  coord_t ctrl_y;
  coord_t end_x;
  coord_t end_y;
  logic   is_line;
  coord_t scan_y;

  modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                  is_line, scan_y, input ready);
  modport sink (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                is_line, scan_y, output ready);
endinterface

// Crossing result channel.
interface ssc_out_if import ssc_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t cross_x;
  logic   rising;
  logic   last;

  modport source (output valid, cross_x, rising, last, input ready);
  modport sink (input valid, cross_x, rising, last, output ready);
endinterface

[src/ssc_front.sv]
module ssc_front import ssc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  ssc_in_if.sink   in_seg,
  output job_req_t q_req,
  input  logic     q_ready
);

  logic                     f_v_r;
  coord_t                   x0_r, x1_r, x2_r, a_r, b_r, c_r, h_r;
  logic                     line_r;
  logic signed [DISC_W-1:0] bb_r, ac_r, hd_r;

  logic                     accept;
  logic signed [QX_W-1:0]   d_in;
  logic signed [QX_W-1:0]   d;
  logic signed [DISC_W-1:0] disc;
  seg_job_t                 job;

  assign in_seg.ready = !f_v_r || q_ready;
  assign accept       = in_seg.valid && in_seg.ready;

  // Second-order y coefficient of the incoming request.
  assign d_in = QX_W'(in_seg.start_y) - (QX_W'(in_seg.ctrl_y) <<< 1) + QX_W'(in_seg.end_y);

  // Capture the request together with the discriminant products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (accept) begin
      f_v_r <= 1'b1;
    end else if (q_ready) begin
      f_v_r <= 1'b0;
    end
    if (accept) begin
      x0_r   <= in_seg.start_x;
      x1_r   <= in_seg.ctrl_x;
      x2_r   <= in_seg.end_x;
      a_r    <= in_seg.start_y;
      b_r    <= in_seg.ctrl_y;
      c_r    <= in_seg.end_y;
      h_r    <= in_seg.scan_y;
      line_r <= in_seg.is_line;
      bb_r   <= DISC_W'(in_seg.ctrl_y) * DISC_W'(in_seg.ctrl_y);
      ac_r   <= DISC_W'(in_seg.start_y) * DISC_W'(in_seg.end_y);
      hd_r   <= DISC_W'(in_seg.scan_y) * DISC_W'(d_in);
    end
  end

  // Classify the segment and prepare the fractions for the solver.
  always_comb begin
    d    = QX_W'(a_r) - (QX_W'(b_r) <<< 1) + QX_W'(c_r);
    disc = bb_r - ac_r + hd_r;

    job.x0   = x0_r;
    job.dx1  = DX_W'(x1_r) - DX_W'(x0_r);
    job.qx   = QX_W'(x0_r) - (QX_W'(x1_r) <<< 1) + QX_W'(x2_r);
    job.dx2  = DX_W'(x2_r) - DX_W'(x0_r);
    job.num1 = NUM_W'(h_r) - NUM_W'(a_r);
    job.e    = (NUM_W'(a_r) - NUM_W'(b_r)) <<< ROOT_XBITS;
    job.rad  = RAD_W'(disc[RAD_W-2*ROOT_XBITS-1:0]) << (2 * ROOT_XBITS);

    if (line_r) begin
      job.kind  = KIND_LINE;
      job.den   = NUM_W'(c_r) - NUM_W'(a_r);
      job.rise1 = c_r > a_r;
    end else if (d == '0) begin
      job.kind  = KIND_LINQ;
      job.den   = (NUM_W'(b_r) - NUM_W'(a_r)) <<< 1;
      job.rise1 = b_r > a_r;
    end else begin
      job.kind  = (disc < 0) ? KIND_NONE : KIND_QUAD;
      job.den   = NUM_W'(d) <<< ROOT_XBITS;
      job.rise1 = 1'b1;
    end
  end

  assign q_req.valid = f_v_r;
  assign q_req.job   = job;

endmodule

[src/ssc_queue.sv]
module ssc_queue import ssc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t push_req,
  output logic     push_ready,
  output job_req_t pop_req,
  input  logic     pop
);

  seg_job_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign push_ready    = cnt_r != 2'd2;
  assign push          = push_req.valid && push_ready;
  assign pop_req.valid = cnt_r != 2'd0;
  assign pop_req.job   = mem_r[rd_ptr_r];

  // Two-entry queue between classification and solving.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_req.job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue occupancy beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> cnt_r != 2'd0)
    else $error("pop from empty queue");

endmodule

[src/ssc_back.sv]
module ssc_back import ssc_pkg::*; #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t q_req,
  output logic     q_pop,
  ssc_out_if.source out_cross
);

  localparam int F     = PARAM_FRAC_BITS;
  localparam int T_W   = F + 1;
  localparam int DIV_W = F + 36;
  localparam int P1_W  = F + 23;
  localparam int LS_W  = F + 24;
  localparam int P_W   = F + 24;
  localparam int M2_W  = F + 26;
  localparam int M3_W  = 2 * F + 1;
  localparam int M_W   = F + 28;
  localparam int CNT_W = $clog2(F + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQRT = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_DIVI = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_EV1  = 4'd5;
  localparam logic [3:0] ST_EV2  = 4'd6;
  localparam logic [3:0] ST_EV3  = 4'd7;
  localparam logic [3:0] ST_EV4  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]              state_r;
  seg_job_t                job_r;
  logic [RAD_W-1:0]        rad_r, root_r, bit_r;
  logic signed [NUM_W-1:0] num1_r, num2_r, den_r;
  logic                    v1_r, v2_r, slot_r;
  logic [DIV_W-1:0]        div_n_r, div_d_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [T_W-1:0]          t_r;
  logic signed [P1_W-1:0]  prod1_r;
  logic signed [P_W-1:0]   p_r;
  logic signed [M2_W-1:0]  prod2_r;
  logic [M3_W-1:0]         prod3_r;
  coord_t                  xres_r;
  logic                    out_v_r, out_rise_r, out_last_r;
  coord_t                  out_x_r;

  logic [RAD_W-1:0]        sq_sum, root_step;
  logic                    sq_ge;
  logic signed [NUM_W-1:0] root_s;
  logic                    den_neg;
  logic signed [NUM_W-1:0] dn, n1, n2, num_sel;
  logic                    ok1, ok2, div_ge;
  logic signed [T_W:0]     ts;
  logic signed [LS_W-1:0]  ls;
  logic signed [M_W-1:0]   m;
  logic                    out_free;
  logic                    out_load;

  // One bit of the square root per cycle.
  assign sq_sum    = root_r + bit_r;
  assign sq_ge     = rad_r >= sq_sum;
  assign root_step = sq_ge ? (root_r >> 1) + bit_r : root_r >> 1;
  assign root_s    = NUM_W'($signed({1'b0, root_step[ROOT_W-1:0]}));

  // Sign normalisation and range test of both parameter fractions.
  always_comb begin
    den_neg = den_r < 0;
    dn      = den_neg ? -den_r : den_r;
    n1      = den_neg ? -num1_r : num1_r;
    n2      = den_neg ? -num2_r : num2_r;
    ok1     = (dn != '0) && (n1 >= 0) && (n1 <= dn);
    ok2     = (job_r.kind == KIND_QUAD) && (dn != '0) && (n2 >= 0) && (n2 <= dn);
  end

  assign num_sel = slot_r ? num2_r : num1_r;
  assign div_ge  = div_n_r >= div_d_r;
  assign ts      = $signed({1'b0, t_r});

  // Final x sums for lines and curves, rounded to nearest.
  assign ls = (LS_W'(job_r.x0) <<< F) + LS_W'(prod1_r) + LS_W'(1 << (F - 1));
  assign m  = (M_W'(job_r.x0) <<< F) + M_W'(prod2_r)
            + M_W'($signed({1'b0, prod3_r[M3_W-1:F]})) + M_W'(1 << (F - 1));

  assign q_pop    = (state_r == ST_IDLE) && q_req.valid;
  assign out_free = !out_v_r || out_cross.ready;
  assign out_load = (state_r == ST_OUT) && out_free;

  // Solver sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_cross.valid && out_cross.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_req.valid) begin
            job_r  <= q_req.job;
            den_r  <= q_req.job.den;
            num1_r <= q_req.job.num1;
            num2_r <= '0;
            rad_r  <= q_req.job.rad;
            root_r <= '0;
            bit_r  <= RAD_W'(1) << (RAD_W - 2);
            if (q_req.job.kind == KIND_QUAD) begin
              state_r <= ST_SQRT;
            end else if (q_req.job.kind != KIND_NONE) begin
              state_r <= ST_CHK;
            end
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            rad_r <= rad_r - sq_sum;
          end
          root_r <= root_step;
          bit_r  <= bit_r >> 2;
          if (bit_r == RAD_W'(1)) begin
            num1_r  <= job_r.e + root_s;
            num2_r  <= job_r.e - root_s;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          num1_r <= n1;
          num2_r <= n2;
          den_r  <= dn;
          v1_r   <= ok1;
          v2_r   <= ok2;
          slot_r <= !ok1;
          state_r <= (ok1 || ok2) ? ST_DIVI : ST_IDLE;
        end
        ST_DIVI: begin
          div_n_r <= (DIV_W'(num_sel) << (F + 1)) + DIV_W'(den_r);
          div_d_r <= DIV_W'(den_r) << (F + 1);
          t_r     <= '0;
          cnt_r   <= CNT_W'(F);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_ge) begin
            div_n_r <= div_n_r - div_d_r;
          end
          t_r     <= {t_r[T_W-2:0], div_ge};
          div_d_r <= div_d_r >> 1;
          if (cnt_r == '0) begin
            state_r <= ST_EV1;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_EV1: begin
          if (job_r.kind == KIND_LINE) begin
            prod1_r <= P1_W'(ts) * P1_W'(job_r.dx2);
          end else begin
            prod1_r <= P1_W'(ts) * P1_W'(job_r.qx);
          end
          state_r <= ST_EV2;
        end
        ST_EV2: begin
          if (job_r.kind == KIND_LINE) begin
            xres_r  <= ls[F +: COORD_W];
            state_r <= ST_OUT;
          end else begin
            p_r     <= (P_W'(job_r.dx1) <<< (F + 1)) + P_W'(prod1_r);
            state_r <= ST_EV3;
          end
        end
        ST_EV3: begin
          prod2_r <= M2_W'(ts) * M2_W'($signed(p_r[P_W-1:F]));
          prod3_r <= M3_W'(t_r) * M3_W'(p_r[F-1:0]);
          state_r <= ST_EV4;
        end
        ST_EV4: begin
          xres_r  <= m[F +: COORD_W];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_x_r    <= xres_r;
            out_rise_r <= slot_r ? 1'b0 : job_r.rise1;
            out_last_r <= slot_r || !v2_r;
            if (!slot_r && v2_r) begin
              slot_r  <= 1'b1;
              state_r <= ST_DIVI;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_cross.valid   = out_v_r;
  assign out_cross.cross_x = out_x_r;
  assign out_cross.rising  = out_rise_r;
  assign out_cross.last    = out_last_r;

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == ST_EV1 |-> t_r <= (T_W'(1) << F))
    else $error("parameter beyond one");
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == ST_OUT |-> (slot_r ? v2_r : v1_r))
    else $error("emitting a rejected root");

endmodule

[src/segment_scanline_crossing.sv]
// Scanline crossing of one outline segment (line or quadratic curve). Each
// request gives zero, one or two crossings on the result channel, the last of
// them flagged; a curve gives its rising root first. The front end takes one
// request per cycle into a two-entry queue while that queue has room, so
// requests are accepted while the solver is busy. The solver handles one
// segment at a time: a line goes through a range check, the bit-serial
// divider and the x evaluation; a curve first runs the 32-step square root,
// then the divider and evaluation for each root that lies on the segment.
module segment_scanline_crossing import ssc_pkg::*; #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  ssc_in_if.sink    in_seg,
  ssc_out_if.source out_cross
);

  job_req_t push_req, pop_req;
  logic     push_ready, pop;

  ssc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (in_seg),
    .q_req   (push_req),
    .q_ready (push_ready)
  );

  ssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_req   (push_req),
    .push_ready (push_ready),
    .pop_req    (pop_req),
    .pop        (pop)
  );

  ssc_back #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_req     (pop_req),
    .q_pop     (pop),
    .out_cross (out_cross)
  );

endmodule
